// ===== src/dspe_pkg.sv =====
`default_nettype none

package dspe_pkg;

   // Decay factors are unsigned Q0.16
   localparam int DECAY_BITS = 16;
   localparam int DECAY_FRAC = 16;

   // Configuration register file: four groups of four decays each
   localparam int CSR_GROUPS       = 4;
   localparam int DECAYS_PER_GROUP = 4;
   localparam int CSR_DATA_BITS    = DECAY_BITS * DECAYS_PER_GROUP;
   localparam int CSR_INDEX_BITS   = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAYS_A = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAYS_B = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAYS_C = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAYS_D = 4'd3;

   // Stream widths on the ports
   localparam int PORT_LEVEL_BITS = 16;

   // Control that travels with an item from cell to cell
   typedef struct packed {
      logic valid;
      logic frame_start;
   } dspe_ctl_type;

endpackage

`default_nettype wire

// ===== src/dspe_cell.sv =====
`default_nettype none

module dspe_cell
   import dspe_pkg::*;
#(
   parameter int STAGE      = 0,
   parameter int LEVEL_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire dspe_ctl_type          in_ctl,
   input  wire logic [LEVEL_BITS-1:0] in_level,
   input  wire logic [LEVEL_BITS-1:0] in_first,
   input  wire logic [DECAY_BITS-1:0] decay,
   output      dspe_ctl_type          out_ctl,
   output      logic [LEVEL_BITS-1:0] out_level,
   output      logic [LEVEL_BITS-1:0] out_first
);

   localparam int DEPTH     = 1 << STAGE;
   localparam int CNT_BITS  = STAGE + 1;
   localparam int PROD_BITS = DECAY_BITS + LEVEL_BITS;

   dspe_ctl_type          ctl_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [CNT_BITS-1:0]   cnt_in;
   logic                  near_in;
   logic                  near_ff;
   logic [LEVEL_BITS-1:0] level_ff;
   logic [LEVEL_BITS-1:0] first_ff;
   logic [LEVEL_BITS-1:0] rd_ff;
   logic                  take;
   logic [LEVEL_BITS-1:0] back;
   logic [PROD_BITS-1:0]  prod;
   logic [LEVEL_BITS-1:0] scaled;

   assign take = advance && in_ctl.valid;

   // Count samples since the picture start, saturating at the look-back distance
   always_comb begin
      if (in_ctl.frame_start) begin
         near_in = 1'b1;
         cnt_in  = CNT_BITS'(1);
      end else begin
         near_in = (cnt_ff < CNT_BITS'(DEPTH));
         cnt_in  = near_in ? cnt_ff + CNT_BITS'(1) : cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (advance) begin
            ctl_ff <= in_ctl;
         end
         if (take) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // Hold the item's payload for the compare step
   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= in_level;
         first_ff <= in_first;
         near_ff  <= near_in;
      end
   end

   // Delay line: read the old sample and store the new one at the same slot
   generate
      if (STAGE == 0) begin : g_reg
         logic [LEVEL_BITS-1:0] hist_ff;

         always_ff @(posedge clock) begin
            if (take) begin
               hist_ff <= in_level;
               rd_ff   <= hist_ff;
            end
         end
      end else begin : g_mem
         logic [LEVEL_BITS-1:0] hist_mem [DEPTH];
         logic [STAGE-1:0]      ptr_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               ptr_ff <= '0;
            end else if (take) begin
               ptr_ff <= ptr_ff + STAGE'(1);
            end
         end

         always_ff @(posedge clock) begin
            if (take) begin
               hist_mem[ptr_ff] <= in_level;
               rd_ff            <= hist_mem[ptr_ff];
            end
         end
      end
   endgenerate

   // Decay the look-back sample and keep the larger value
   always_comb begin
      back      = near_ff ? first_ff : rd_ff;
      prod      = PROD_BITS'(decay) * PROD_BITS'(back);
      scaled    = prod[DECAY_FRAC +: LEVEL_BITS];
      out_level = (scaled > level_ff) ? scaled : level_ff;
      out_first = first_ff;
      out_ctl   = ctl_ff;
   end

endmodule

`default_nettype wire

// ===== src/doubling_scan_peak_envelope.sv =====
// Peak envelope detector built as a row of PASSES cells, one per look-back pass.
// Input channel req_*: one level sample per item in raster order, with tuser set
// on the first sample of a picture. Result channel rsp_*: one envelope per item,
// in input order. Configuration channel csr_*: index 0 to 3 selects a group of
// four 16-bit decays (lowest pass in the lowest bits); other indexes are ignored.
// Write decays only while no item is in flight.
// Cell k keeps a delay line of 2^k samples in a local memory (a register for
// cell 0), read and written at one slot per item, and hands its result to cell
// k+1 each cycle that the row advances. Throughput: one item per clock while
// the row is not stalled. Cell 0 loads an item at the accepting edge; it then
// passes through each further cell in order and then the output register.
// Reset clears the decays, the picture state and the delay-line pointers; the
// delay lines themselves are not cleared, since no slot is read before the
// current picture has written it. Samples before the first picture start form
// a picture with a first level of zero.
// When the receiver holds rsp_tready low with a result waiting, the whole row
// of cells stalls and req_tready drops until the result is taken.
`default_nettype none

module doubling_scan_peak_envelope
   import dspe_pkg::*;
#(
   parameter int PASSES     = 14,
   parameter int LEVEL_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [PORT_LEVEL_BITS-1:0] req_tdata,   // [15:0] level
   input  wire logic                       req_tuser,   // [0] frame_start
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [PORT_LEVEL_BITS-1:0] rsp_tdata,   // [15:0] envelope
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_data
);

   logic [CSR_GROUPS-1:0][CSR_DATA_BITS-1:0] decay_ff;
   logic [LEVEL_BITS-1:0]                    first_level_ff;
   logic                                     rsp_valid_ff;
   logic [PORT_LEVEL_BITS-1:0]               rsp_data_ff;
   logic                                     advance;
   logic                                     req_take;
   logic [LEVEL_BITS-1:0]                    req_level;

   dspe_ctl_type                             chain_ctl   [PASSES+1];
   logic [LEVEL_BITS-1:0]                    chain_level [PASSES+1];
   logic [LEVEL_BITS-1:0]                    chain_first [PASSES+1];

   // Stall the whole row while a result waits
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_take   = req_tvalid && advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_level = LEVEL_BITS'(req_tdata);

   // Decay register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DECAYS_A: decay_ff[0] <= csr_data;
            CSR_DECAYS_B: decay_ff[1] <= csr_data;
            CSR_DECAYS_C: decay_ff[2] <= csr_data;
            CSR_DECAYS_D: decay_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // Latch the first level of each picture
   always_ff @(posedge clock) begin
      if (reset) begin
         first_level_ff <= '0;
      end else if (req_take && req_tuser) begin
         first_level_ff <= req_level;
      end
   end

   // Feed the first cell
   assign chain_ctl[0].valid       = req_tvalid;
   assign chain_ctl[0].frame_start = req_tuser;
   assign chain_level[0]           = req_level;
   assign chain_first[0]           = req_tuser ? req_level : first_level_ff;

   // Row of pass cells
   generate
      for (genvar k = 0; k < PASSES; k++) begin : g_cell
         dspe_cell #(
            .STAGE      (k),
            .LEVEL_BITS (LEVEL_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .in_ctl    (chain_ctl[k]),
            .in_level  (chain_level[k]),
            .in_first  (chain_first[k]),
            .decay     (decay_ff[k / DECAYS_PER_GROUP]
                                [DECAY_BITS * (k % DECAYS_PER_GROUP) +: DECAY_BITS]),
            .out_ctl   (chain_ctl[k+1]),
            .out_level (chain_level[k+1]),
            .out_first (chain_first[k+1])
         );
      end
   endgenerate

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_ctl[PASSES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= PORT_LEVEL_BITS'(chain_level[PASSES]);
      end
   end

`ifndef SYNTHESIS
   // The last pass never lowers the value it receives
   assert property (@(posedge clock) disable iff (reset)
      chain_ctl[PASSES].valid |-> (chain_level[PASSES] >= g_cell[PASSES-1].u_cell.level_ff))
   else $error("envelope fell below its pass input");

   // A picture start records its level as the look-back fallback
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser) |=> (first_level_ff == $past(req_level)))
   else $error("picture first level not captured");

   // A stall freezes the item leaving the row
   assert property (@(posedge clock) disable iff (reset)
      (!advance && chain_ctl[PASSES].valid && !$past(reset)) |=>
         $stable(chain_ctl[PASSES]) && $stable(chain_level[PASSES]))
   else $error("row moved during a stall");

   // Every item leaving the row reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (advance && chain_ctl[PASSES].valid) |=> rsp_valid_ff)
   else $error("result lost at the output register");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb
   import dspe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PASSES     = 14;
   localparam int LEVEL_BITS = 16;
   localparam int LATENCY    = PASSES + 1;
   localparam int LINE_DEPTH = (1 << PASSES) - 1;
   localparam int COUNT_CAP  = 1 << (PASSES - 1);

   typedef enum int {DECAY_ZERO, DECAY_FULL, DECAY_ANY, DECAY_HIGH, DECAY_SOLO} decay_mode_type;

   // One row of the directed part: either a register write or a sample
   typedef struct {
      logic                      is_csr;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
      logic [15:0]               level;
      logic                      frame_start;
      logic                      typed;
      logic [15:0]               envelope;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [PORT_LEVEL_BITS-1:0] req_tdata = '0;   // [15:0] level
   logic                       req_tuser = 1'b0; // [0] frame_start
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b1;
   logic [PORT_LEVEL_BITS-1:0] rsp_tdata;        // [15:0] envelope
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data = '0;

   // Model state of the detector
   logic [CSR_DATA_BITS-1:0] decay_grp [CSR_GROUPS];
   logic [15:0]              line_mem [LINE_DEPTH];
   logic [15:0]              pic_first;
   int unsigned              pic_count;
   logic [15:0]              wr_pos;

   logic [15:0]  pending_envelopes [$];
   plan_row_type plan [$];
   int           mismatches = 0;
   int           idle_pct = 20;
   int           stall_pct = 20;
   int           stall_left = 0;
   logic         calm = 1'b0;

   doubling_scan_peak_envelope #(
      .PASSES(PASSES),
      .LEVEL_BITS(LEVEL_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Run each pass: max of its input and the decayed look-back of its input
   function automatic logic [15:0] predict_envelope(input logic [15:0] level,
                                                    input logic frame_start);
      int unsigned n;
      int unsigned d;
      int unsigned slot;
      logic [15:0] v;
      logic [15:0] back;
      logic [15:0] decay;
      logic [31:0] prod;
      v = level;
      if (frame_start) begin
         n = 0;
         pic_first = v;
      end else begin
         n = pic_count;
      end
      for (int k = 0; k < PASSES; k++) begin
         d     = 1 << k;
         slot  = (d - 1) + (wr_pos & (d - 1));
         back  = (n < d) ? pic_first : line_mem[slot];
         line_mem[slot] = v;
         decay = decay_grp[k >> 2][16 * (k & 3) +: 16];
         prod  = decay * back;
         if (prod[31:16] > v) v = prod[31:16];
      end
      wr_pos    = wr_pos + 16'd1;
      pic_count = (n < COUNT_CAP) ? n + 1 : COUNT_CAP;
      return v;
   endfunction

   function automatic plan_row_type item_row(input logic [15:0] level,
                                             input logic frame_start,
                                             input logic typed,
                                             input logic [15:0] envelope);
      plan_row_type r;
      r = '{1'b0, '0, '0, level, frame_start, typed, envelope};
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_BITS-1:0] index,
                                            input logic [CSR_DATA_BITS-1:0] data);
      plan_row_type r;
      r = '{1'b1, index, data, '0, 1'b0, 1'b0, '0};
      return r;
   endfunction

   // Append one row to the directed table
   task automatic add_row(input plan_row_type r);
      plan.insert(plan.size(), r);
   endtask

   // Mostly quiet levels with sparse peaks, plus the extremes
   function automatic logic [15:0] rand_level();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom);
         default: return ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] rand_decays(input decay_mode_type mode,
                                                            input int grp, input int solo);
      logic [CSR_DATA_BITS-1:0] word;
      int pass;
      word = '0;
      for (int j = 0; j < DECAYS_PER_GROUP; j++) begin
         pass = grp * DECAYS_PER_GROUP + j;
         case (mode)
            DECAY_ZERO: word[16*j +: 16] = 16'h0000;
            DECAY_FULL: word[16*j +: 16] = 16'hFFFF;
            DECAY_ANY:  word[16*j +: 16] = 16'($urandom);
            DECAY_HIGH: word[16*j +: 16] = ($urandom_range(0, 3) == 0) ? 16'h0000
                                           : 16'($urandom_range(16'hC000, 16'hFFFF));
            default:    word[16*j +: 16] = (pass == solo) ? 16'hFFFF : 16'h0000;
         endcase
      end
      return word;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("tb: mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
      mismatches++;
   endtask

   // Offer one sample, hold it until taken, then queue its envelope
   task automatic send_sample(input logic [15:0] level, input logic frame_start,
                              input logic typed, input logic [15:0] envelope);
      logic [15:0] want;
      req_tvalid <= 1'b1;
      req_tdata  <= level;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      want = predict_envelope(level, frame_start);
      if (typed) want = envelope;
      pending_envelopes.insert(pending_envelopes.size(), want);
   endtask

   task automatic maybe_idle();
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Drain the row of cells before touching the decays
   task automatic go_idle();
      req_tvalid <= 1'b0;
      while (pending_envelopes.size() != 0) @(posedge clock);
   endtask

   task automatic write_decays(input logic [CSR_INDEX_BITS-1:0] index,
                               input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index <= CSR_DECAYS_D) decay_grp[index[1:0]] = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_setting(input decay_mode_type mode);
      int solo;
      logic [CSR_INDEX_BITS-1:0] stray;
      solo  = $urandom_range(0, PASSES - 1);
      stray = CSR_INDEX_BITS'($urandom_range(CSR_DECAYS_D + 1, (1 << CSR_INDEX_BITS) - 1));
      go_idle();
      if ($urandom_range(0, 1)) write_decays(stray, {$urandom, $urandom});
      for (int g = 0; g < CSR_GROUPS; g++)
         write_decays(CSR_INDEX_BITS'(CSR_DECAYS_A + g), rand_decays(mode, g, solo));
   endtask

   // Send pictures of random length, mostly short, some long
   task automatic send_pictures(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 600) : $urandom_range(1, 64);
         for (int i = 0; i < len && sent < count; i++) begin
            send_sample(rand_level(), i == 0, 1'b0, '0);
            maybe_idle();
            sent++;
         end
      end
   endtask

   // Receiver backpressure in bursts
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each taken envelope with the oldest one queued
   always @(posedge clock) begin : check_results
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_envelopes.size() == 0) begin
            report_mismatch("envelope with no sample pending", rsp_tdata, '0);
         end else begin
            want = pending_envelopes.pop_front();
            if (rsp_tdata !== want) report_mismatch("envelope", rsp_tdata, want);
         end
      end
   end

   initial begin : stimulus
      decay_mode_type mode;
      for (int g = 0; g < CSR_GROUPS; g++) decay_grp[g] = '0;
      pic_first = '0;
      pic_count = 0;
      wr_pos    = '0;

      // Decays reset to zero: every pass is transparent until written
      add_row(item_row(16'h1234, 1'b0, 1'b1, 16'h1234)); // before any picture start
      add_row(item_row(16'hFFFF, 1'b0, 1'b1, 16'hFFFF));
      add_row(item_row(16'h0000, 1'b1, 1'b1, 16'h0000));
      add_row(item_row(16'h0001, 1'b0, 1'b1, 16'h0001));
      add_row(item_row(16'h8000, 1'b1, 1'b1, 16'h8000));
      // Full-scale decays on every pass
      add_row(csr_row(CSR_DECAYS_A, '1));
      add_row(csr_row(CSR_DECAYS_B, '1));
      add_row(csr_row(CSR_DECAYS_C, '1));
      add_row(csr_row(CSR_DECAYS_D, '1));
      add_row(item_row(16'hFFFF, 1'b1, 1'b0, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b0, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b0, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b0, '0));
      add_row(item_row(16'h4000, 1'b0, 1'b0, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b0, '0));
      // Picture start at zero: look-back clamps to the new first sample
      add_row(item_row(16'h0000, 1'b1, 1'b0, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b0, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b0, '0));
      // Out-of-range indexes leave the decays alone
      add_row(csr_row({CSR_INDEX_BITS{1'b1}}, 64'h0123_4567_89AB_CDEF));
      add_row(csr_row(CSR_INDEX_BITS'(CSR_DECAYS_D + 1), '0));
      add_row(item_row(16'hFFFF, 1'b1, 1'b0, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b0, '0));
      // Half-scale decay on passes 0 and 2 only in the first group
      add_row(csr_row(CSR_DECAYS_A, 64'h0000_8000_0000_8000));
      add_row(item_row(16'hFFFF, 1'b0, 1'b0, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b0, '0));
      // Back to transparent
      add_row(csr_row(CSR_DECAYS_A, '0));
      add_row(csr_row(CSR_DECAYS_B, '0));
      add_row(csr_row(CSR_DECAYS_C, '0));
      add_row(csr_row(CSR_DECAYS_D, '0));
      add_row(item_row(16'h0000, 1'b0, 1'b1, 16'h0000));
      add_row(item_row(16'hABCD, 1'b0, 1'b1, 16'hABCD));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            go_idle();
            write_decays(plan[i].index, plan[i].data);
         end else begin
            send_sample(plan[i].level, plan[i].frame_start, plan[i].typed, plan[i].envelope);
            maybe_idle();
         end
      end

      // Random phases, each with its own decay setting and idling mix
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 5)
            0:       mode = DECAY_HIGH;
            1:       mode = DECAY_ANY;
            2:       mode = DECAY_SOLO;
            3:       mode = DECAY_FULL;
            default: mode = DECAY_ZERO;
         endcase
         idle_pct  = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
         stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(5, 40);
         write_setting(mode);
         send_pictures(200);
      end

      // Closing stretch with no idling on either side
      write_setting(DECAY_ANY);
      calm = 1'b1;
      send_pictures(150);

      go_idle();
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
src/dspe_pkg.sv
src/dspe_cell.sv
src/doubling_scan_peak_envelope.sv
dv/tb.sv
